// ===== hdl/keymap_layer_resolver_defines.svh =====
// Assertion macros used by the resolver controller RTL.
`ifndef KEYMAP_LAYER_RESOLVER_DEFINES_SVH
`define KEYMAP_LAYER_RESOLVER_DEFINES_SVH

// Same-cycle implication, checked on every edge out of reset.
`define KLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/klr_pkg.sv =====
package klr_pkg;

    localparam int LAYERS_DEF = 16;
    localparam int ROWS_DEF   = 8;
    localparam int COLS_DEF   = 16;
    localparam int MASK_W     = 16;
    localparam int KC_W       = 16;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [3:0] {
        K_LOOKUP  = 4'd0,
        K_ON      = 4'd1,
        K_OFF     = 4'd2,
        K_TOGGLE  = 4'd3,
        K_SET     = 4'd4,
        K_OR      = 4'd5,
        K_AND     = 4'd6,
        K_XOR     = 4'd7,
        K_DEF_SET = 4'd8,
        K_TRI     = 4'd9,
        K_WRITE   = 4'd10,
        K_CLEAR   = 4'd11
    } t_klr_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAPPED = 2'd0,
        CFG_TRANS  = 2'd1,
        CFG_NONE   = 2'd2
    } t_klr_cfg;

    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        layer_index;
        logic [7:0]        second_layer;
        logic [7:0]        target_layer;
        logic [7:0]        row;
        logic [7:0]        col;
        logic [MASK_W-1:0] mask;
        logic [KC_W-1:0]   write_code;
    } t_klr_cmd;

    typedef struct packed {
        logic [KC_W-1:0]   keycode;
        logic [MASK_W-1:0] active_state;
        logic [MASK_W-1:0] default_state;
        logic [3:0]        highest_layer;
        logic              rejected;
    } t_klr_res;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch command, start scan at top layer
        logic finish;  // apply command, register result with none code
        logic rd;      // read keymap at current scan layer
        logic step;    // move scan one layer down
        logic fin_hit; // register result with keymap data
    } t_klr_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_go;    // lookup with a valid position
        logic cand;       // current layer is searched and mapped
        logic layer_zero; // scan is at layer 0
        logic hit;        // read data is not transparent
    } t_klr_sts;

endpackage

// ===== hdl/klr_ctrl.sv =====
`include "keymap_layer_resolver_defines.svh"

module klr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  klr_pkg::t_klr_sts i_sts,
    output klr_pkg::t_klr_ctl o_ctl,
    output logic              o_busy,
    output logic              o_done
);
    import klr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.scan_go) begin
                    n_state = S_SCAN;
                end else begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.cand) begin
                    o_ctl.rd = 1'b1;
                    n_state  = S_CHECK;
                end else if (i_sts.layer_zero) begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    o_ctl.fin_hit = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.layer_zero) begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.step = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    `KLR_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done longer than one cycle")
    `KLR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !r_done,
                     "accepted item did not make block busy")
    `KLR_ASSERT_NEXT(a_rd_check, i_clk, i_rst_n, o_ctl.rd, r_state == S_CHECK,
                     "keymap read not followed by check")
    `KLR_ASSERT_NOW(a_step_nonzero, i_clk, i_rst_n, o_ctl.step, !i_sts.layer_zero,
                    "scan stepped below layer 0")

endmodule

// ===== hdl/klr_dp.sv =====
module klr_dp #(
    parameter int LAYERS = klr_pkg::LAYERS_DEF,
    parameter int ROWS   = klr_pkg::ROWS_DEF,
    parameter int COLS   = klr_pkg::COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  klr_pkg::t_klr_cmd               i_cmd,
    input  logic                            i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [klr_pkg::KC_W-1:0]        i_cfg_wdata,
    input  klr_pkg::t_klr_ctl               i_ctl,
    output klr_pkg::t_klr_sts               o_sts,
    output klr_pkg::t_klr_res               o_result
);
    import klr_pkg::*;

    localparam int NLAY  = (LAYERS < MASK_W) ? LAYERS : MASK_W;
    localparam int LW    = $clog2(NLAY);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH = NLAY * ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [LW-1:0] lay,
                                             input logic [RW-1:0] rw,
                                             input logic [CW-1:0] cl);
        return AW'((int'(lay) * ROWS + int'(rw)) * COLS + int'(cl));
    endfunction

    t_klr_cmd          r_cmd;
    logic [4:0]        r_mapped;
    logic [KC_W-1:0]   r_trans;
    logic [KC_W-1:0]   r_none;
    logic [MASK_W-1:0] r_active;
    logic [MASK_W-1:0] r_default;
    logic [NLAY-1:0]   r_search;
    logic [LW-1:0]     r_layer;
    logic [KC_W-1:0]   r_rdata;
    t_klr_res          r_result;
    logic [KC_W-1:0]   r_keymap [DEPTH];

    logic              l1ok, l2ok, l3ok, pos_ok;
    logic [MASK_W-1:0] b1, b2, b3;
    logic [MASK_W-1:0] n_active, n_default;
    logic [MASK_W-1:0] load_search;
    logic              rej;
    logic [3:0]        hi;
    logic              mem_we;
    logic [AW-1:0]     waddr, raddr;

    assign l1ok   = r_cmd.layer_index < 8'(NLAY);
    assign l2ok   = r_cmd.second_layer < 8'(NLAY);
    assign l3ok   = r_cmd.target_layer < 8'(NLAY);
    assign pos_ok = (r_cmd.row < 8'(ROWS)) && (r_cmd.col < 8'(COLS));
    assign b1     = MASK_W'(1) << r_cmd.layer_index[3:0];
    assign b2     = MASK_W'(1) << r_cmd.second_layer[3:0];
    assign b3     = MASK_W'(1) << r_cmd.target_layer[3:0];

    always_comb begin
        n_active  = r_active;
        n_default = r_default;
        rej       = 1'b0;
        case (r_cmd.kind)
            K_LOOKUP:  rej = !pos_ok;
            K_ON:      if (l1ok) n_active = r_active | b1;  else rej = 1'b1;
            K_OFF:     if (l1ok) n_active = r_active & ~b1; else rej = 1'b1;
            K_TOGGLE:  if (l1ok) n_active = r_active ^ b1;  else rej = 1'b1;
            K_SET:     n_active  = r_cmd.mask;
            K_OR:      n_active  = r_active | r_cmd.mask;
            K_AND:     n_active  = r_active & r_cmd.mask;
            K_XOR:     n_active  = r_active ^ r_cmd.mask;
            K_DEF_SET: n_default = r_cmd.mask;
            K_TRI: begin
                if (!(l1ok && l2ok && l3ok)) begin
                    rej = 1'b1;
                end else if (((r_active & b1) != '0) && ((r_active & b2) != '0)) begin
                    n_active = r_active | b3;
                end else begin
                    n_active = r_active & ~b3;
                end
            end
            K_WRITE:   rej = !(l1ok && pos_ok);
            K_CLEAR:   n_active = '0;
            default:   ;
        endcase
    end

    // highest active layer below NLAY
    always_comb begin
        hi = '0;
        for (int i = 0; i < NLAY; i++) begin
            if (n_active[i]) hi = 4'(i);
        end
    end

    assign mem_we = i_ctl.finish && (r_cmd.kind == K_WRITE) && !rej;
    assign waddr  = f_addr(r_cmd.layer_index[LW-1:0], r_cmd.row[RW-1:0], r_cmd.col[CW-1:0]);
    assign raddr  = f_addr(r_layer, r_cmd.row[RW-1:0], r_cmd.col[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_keymap[waddr] <= r_cmd.write_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_keymap[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped  <= 5'd16;
            r_trans   <= KC_W'(1);
            r_none    <= '0;
            r_active  <= '0;
            r_default <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAPPED: r_mapped <= i_cfg_wdata[4:0];
                    CFG_TRANS:  r_trans  <= i_cfg_wdata;
                    CFG_NONE:   r_none   <= i_cfg_wdata;
                    default:    ;
                endcase
            end
            if (i_ctl.finish) begin
                r_active  <= n_active;
                r_default <= n_default;
            end
        end
    end

    assign load_search = i_cmd.mask | r_default;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_search <= load_search[NLAY-1:0];
            r_layer  <= LW'(NLAY - 1);
        end else if (i_ctl.step) begin
            r_layer  <= r_layer - 1'b1;
        end
        if (i_ctl.finish || i_ctl.fin_hit) begin
            r_result.keycode       <= i_ctl.fin_hit ? r_rdata : r_none;
            r_result.active_state  <= n_active;
            r_result.default_state <= n_default;
            r_result.highest_layer <= hi;
            r_result.rejected      <= rej;
        end
    end

    assign o_sts.scan_go    = (r_cmd.kind == K_LOOKUP) && pos_ok;
    assign o_sts.cand       = r_search[r_layer] && (5'(r_layer) < r_mapped);
    assign o_sts.layer_zero = (r_layer == '0);
    assign o_sts.hit        = (r_rdata != r_trans);
    assign o_result         = r_result;

endmodule

// ===== hdl/keymap_layer_resolver.sv =====
// Non-lookup commands finish in the exec state; a lookup then walks the layers
// top-down, stepping past skipped ones and reading the keymap at each candidate.
// One item is handled at a time; o_busy stays high until the result is made,
// the next start is taken at the edge that ends the o_done cycle, and o_done
// pulses one cycle with o_result valid (the receiver cannot stall).
// Reset (i_rst_n low, synchronous): masks cleared, config registers to their defaults;
// keymap contents are not cleared and must be written before use.
module keymap_layer_resolver #(
    parameter int LAYERS = klr_pkg::LAYERS_DEF,
    parameter int ROWS   = klr_pkg::ROWS_DEF,
    parameter int COLS   = klr_pkg::COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_start,
    input  klr_pkg::t_klr_cmd             i_cmd,
    output logic                          o_busy,
    // result channel
    output logic                          o_done,
    output klr_pkg::t_klr_res             o_result,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [klr_pkg::KC_W-1:0]      i_cfg_wdata
);
    import klr_pkg::*;

    t_klr_ctl ctl;
    t_klr_sts sts;

    // Controller: idle -> exec; lookups walk layers top-down, one keymap
    // read (registered) per searched and mapped layer, stopping at the first hit.
    klr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Datapath: command latch, layer masks, config registers, keymap memory,
    // scan counter and the result register.
    klr_dp #(
        .LAYERS (LAYERS),
        .ROWS   (ROWS),
        .COLS   (COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_result    (o_result)
    );

endmodule
